/* rtl/ecar_pkg.sv */
// ----------------------------------------------------------------------------
// ecar_pkg
// Shared types and constants for the cellular automaton row core.
// ----------------------------------------------------------------------------
package ecar_pkg;

  // fixed field widths
  localparam int RULE_W  = 8;
  localparam int LEN_W   = 11;
  localparam int IDX_W   = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic [RULE_W-1:0] RULE_RESET = 8'd0;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd1024;

  // register index, taken from paddr bit 2
  localparam logic REG_RULE = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_STEP
  } state_t;

  // configuration handed to the sequencer
  typedef struct packed {
    logic [RULE_W-1:0] rule_number;
    logic [LEN_W-1:0]  row_length;
  } cfg_t;

endpackage

/* rtl/ecar_cell_mem.sv */
// ----------------------------------------------------------------------------
// ecar_cell_mem
// One-bit cell store, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ecar_cell_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [0:DEPTH-1];
  logic rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ecar_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ecar_cfg_regs
// APB-style register file holding the rule number and the row length.
// ----------------------------------------------------------------------------
module ecar_cfg_regs
  import ecar_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [RULE_W-1:0] rule_r, rule_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register write decode
  always_comb begin
    rule_nxt = rule_r;
    len_nxt  = len_r;
    if (wr_en) begin
      case (paddr[2])
        REG_RULE: rule_nxt = pwdata[RULE_W-1:0];
        REG_LEN:  len_nxt  = pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= RULE_RESET;
      len_r  <= LEN_RESET;
    end else begin
      rule_r <= rule_nxt;
      len_r  <= len_nxt;
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      REG_RULE: prdata = {{(PDATA_W-RULE_W){1'b0}}, rule_r};
      REG_LEN:  prdata = {{(PDATA_W-LEN_W){1'b0}}, len_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg.rule_number = rule_r;
  assign cfg.row_length  = len_r;

endmodule

/* rtl/ecar_ctrl.sv */
// ----------------------------------------------------------------------------
// ecar_ctrl
// Request sequencer: clearing pass, cell read/write, and the generation
// sweep with a sliding three-cell window over the cell store.
// ----------------------------------------------------------------------------
module ecar_ctrl
  import ecar_pkg::*;
#(
  parameter int MAX_CELLS = 1024,
  parameter int AW        = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [IDX_W-1:0] in_cell_index,
  input  logic             in_cell_value,
  output logic             out_strobe,
  output logic             out_read_value,
  output logic [LEN_W-1:0] out_alive_count,
  output logic [LEN_W-1:0] out_dead_count,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic             mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic             mem_rdata
);

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0] alive_r, alive_nxt;
  logic             left_r, left_nxt;
  logic             centre_r, centre_nxt;
  logic             strobe_r, strobe_nxt;
  logic             rd_flag_r, rd_flag_nxt;

  logic [LEN_W-1:0] eff_len;
  logic             in_range;
  logic             clr_last;
  logic             pos_last;
  logic             accept;
  logic             right_cell;
  logic [2:0]       code;
  logic             next_cell;

  // effective row length, capped at the store depth
  assign eff_len  = (32'(cfg.row_length) > MAX_CELLS) ? LEN_W'(MAX_CELLS) : cfg.row_length;
  assign in_range = ({1'b0, in_cell_index} < eff_len);
  assign clr_last = (clr_addr_r == AW'(MAX_CELLS - 1));
  assign pos_last = ((pos_r + LEN_W'(1)) == eff_len);
  assign busy     = (state_r != ST_IDLE);
  assign accept   = start & ~busy;

  // window: cells past the row end are dead
  assign right_cell = pos_last ? 1'b0 : mem_rdata;
  assign code       = {left_r, centre_r, right_cell};
  assign next_cell  = cfg.rule_number[code];

  // next state and memory port control
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    alive_nxt    = alive_r;
    left_nxt     = left_r;
    centre_nxt   = centre_r;
    strobe_nxt   = 1'b0;
    rd_flag_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = AW'(in_cell_index);
    mem_wdata    = in_cell_value;
    mem_raddr    = AW'(in_cell_index);
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = 1'b0;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          case (req_t'(in_req_type))
            REQ_WRITE: mem_we = in_range;
            REQ_READ:  rd_flag_nxt = in_range;
            REQ_STEP: begin
              mem_raddr = '0;
              if (eff_len == '0) begin
                alive_nxt = '0;
              end else begin
                strobe_nxt = 1'b0;
                state_nxt  = ST_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        // first cell arrives, prime the window
        left_nxt   = 1'b0;
        centre_nxt = mem_rdata;
        acc_nxt    = '0;
        pos_nxt    = '0;
        mem_raddr  = AW'(1);
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(pos_r);
        mem_wdata  = next_cell;
        mem_raddr  = AW'(pos_r + LEN_W'(2));
        left_nxt   = centre_r;
        centre_nxt = right_cell;
        acc_nxt    = acc_r + LEN_W'(next_cell);
        pos_nxt    = pos_r + LEN_W'(1);
        if (pos_last) begin
          alive_nxt  = acc_r + LEN_W'(next_cell);
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      pos_r      <= '0;
      alive_r    <= '0;
      strobe_r   <= 1'b0;
      rd_flag_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pos_r      <= pos_nxt;
      alive_r    <= alive_nxt;
      strobe_r   <= strobe_nxt;
      rd_flag_r  <= rd_flag_nxt;
    end
  end

  // window and accumulator
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    left_r   <= left_nxt;
    centre_r <= centre_nxt;
  end

  // result fields
  assign out_strobe      = strobe_r;
  assign out_read_value  = rd_flag_r & mem_rdata;
  assign out_alive_count = alive_r;
  assign out_dead_count  = (alive_r <= eff_len) ? (eff_len - alive_r) : '0;

`ifndef NO_ASSERTIONS
  // every result comes from an accepted request or the end of a sweep
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(accept) || $past(state_r == ST_STEP && pos_last)))
    else $error("result strobe without a source");

  // a step request on a non-empty row starts the sweep
  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_STEP && eff_len != '0) |=> (state_r == ST_LOAD))
    else $error("step request did not start a sweep");

  // the sweep never writes outside the row
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (pos_r < eff_len && mem_we))
    else $error("sweep position outside the row");

  // no strobe while the sweep is running
  a_no_strobe_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && !pos_last) |=> !out_strobe)
    else $error("result strobe during a sweep");

  // the clearing pass runs to the last entry
  a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !clr_last) |=> (state_r == ST_CLEAR && busy))
    else $error("clearing pass left early");
`endif

endmodule

/* rtl/elementary_cellular_automaton_row_core.sv */
// ----------------------------------------------------------------------------
// elementary_cellular_automaton_row_core
// One-dimensional two-state cellular automaton row with rule numbering.
// ----------------------------------------------------------------------------
// Usage:
//   A request is a transfer at a clock edge where start is high and busy is
//   low. For write and read requests the result strobe comes in the next
//   cycle and the next request may be issued in that same cycle. Read data
//   comes from the registered cell store read port, alongside the strobe.
//   A generation step sweeps the row once through the cell store, reading
//   one cell ahead and writing one cell back each cycle: busy stays high
//   through the load and step states and the result strobe follows at the end.
//   Every result is on the out_ ports for one cycle, marked by out_strobe;
//   the receiver cannot stall it.
//   After reset the block clears every entry of the cell store, one entry a
//   cycle, with busy high. Register writes through the APB port
//   are taken at any time; change them only while no request is in flight.
// ----------------------------------------------------------------------------
module elementary_cellular_automaton_row_core
  import ecar_pkg::*;
#(
  parameter int MAX_CELLS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [IDX_W-1:0]   in_cell_index,
  input  logic               in_cell_value,
  // result channel
  output logic               out_strobe,
  output logic               out_read_value,
  output logic [LEN_W-1:0]   out_alive_count,
  output logic [LEN_W-1:0]   out_dead_count,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_CELLS);

  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  // configuration registers
  ecar_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // cell store
  ecar_cell_mem #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request sequencer
  ecar_ctrl #(
    .MAX_CELLS (MAX_CELLS),
    .AW        (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_cell_index   (in_cell_index),
    .in_cell_value   (in_cell_value),
    .out_strobe      (out_strobe),
    .out_read_value  (out_read_value),
    .out_alive_count (out_alive_count),
    .out_dead_count  (out_dead_count),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

endmodule
